### sv/line_substring_filter_core_macros.svh
// ---------------------------------------------------------------------------
// line_substring_filter_core_macros.svh
// Assertion macros for the line filter checker.
// ---------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_FILTER_CORE_MACROS_SVH
`define LINE_SUBSTRING_FILTER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("line filter check failed");

// next-cycle implication, disabled during reset
`define LSF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("line filter check failed");

`endif

### sv/lsf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_pkg
// Constants, register indexes and record types of the line filter.
// ---------------------------------------------------------------------------
package lsf_pkg;

  // pattern window and line length counter
  localparam int MAX_PATTERN_BYTES = 32;
  localparam int LENGTH_BITS       = 16;

  // pattern storage: four 64-bit words, byte 0 in the low bits
  localparam int PATTERN_WORDS = 4;
  localparam int WORD_BYTES    = 8;
  localparam int PATTERN_BYTES = PATTERN_WORDS * WORD_BYTES;
  localparam int PAT_IDX_W     = $clog2(PATTERN_BYTES);
  localparam int PAT_LEN_W     = 6;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;

  localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD0  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD1  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD2  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_WORD3  = 3'd5;

  localparam logic [7:0] TERMINATOR_RESET = 8'd10;

  // result field widths
  localparam int LINE_LEN_W    = 16;
  localparam int LINE_NUMBER_W = 32;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // line record queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                  keep;
    logic [LINE_LEN_W-1:0] line_len;
    logic                  length_overflow;
  } line_rec_t;

  typedef struct packed {
    logic      valid;
    line_rec_t rec;
  } rec_xfer_t;

endpackage

### sv/lsf_byte_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_byte_if
// Byte stream channel: valid/ready with one text byte.
// ---------------------------------------------------------------------------
interface lsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
  modport monitor (input valid, input data_byte, input ready);
endinterface

### sv/lsf_line_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_line_if
// Line result channel: valid/ready with verdict, length and line number.
// ---------------------------------------------------------------------------
interface lsf_line_if;
  logic        valid;
  logic        ready;
  logic        keep;
  logic [15:0] line_len;
  logic        length_overflow;
  logic [31:0] line_number;

  modport source (output valid, output keep, output line_len,
                  output length_overflow, output line_number, input ready);
  modport sink (input valid, input keep, input line_len,
                input length_overflow, input line_number, output ready);
  modport monitor (input valid, input keep, input line_len,
                   input length_overflow, input line_number, input ready);
endinterface

### sv/lsf_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_front
// Takes text bytes, keeps the sliding window, line length and match flag,
// and hands a line record to the queue at each terminator.
// ---------------------------------------------------------------------------
module lsf_front
  import lsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lsf_byte_if.sink               text,
  input  logic                   queue_full,
  output rec_xfer_t              push
);

  // configuration registers
  logic [7:0]                        terminator;
  logic [PAT_LEN_W-1:0]              pattern_length;
  logic [PATTERN_BYTES-1:0][7:0]     pattern;

  // line state
  logic [MAX_PATTERN_BYTES-1:0][7:0] window;
  logic [LENGTH_BITS-1:0]            count;
  logic                              ovf;
  logic                              found;

  logic [MAX_PATTERN_BYTES-1:0][7:0] window_next;
  logic [LENGTH_BITS-1:0]            count_next;
  logic                              ovf_next;
  logic                              found_next;
  logic [PAT_LEN_W-1:0]              len_c;
  logic                              all_eq;
  logic                              match;
  logic                              accept;
  logic                              is_term;

  assign text.ready = !queue_full;
  assign accept     = text.valid && text.ready;
  assign is_term    = (text.data_byte == terminator);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      terminator     <= TERMINATOR_RESET;
      pattern_length <= '0;
      pattern        <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TERMINATOR:     terminator <= cfg_data[7:0];
        REG_PATTERN_LENGTH: pattern_length <= cfg_data[PAT_LEN_W-1:0];
        REG_PATTERN_WORD0:  pattern[0*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        REG_PATTERN_WORD1:  pattern[1*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        REG_PATTERN_WORD2:  pattern[2*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        REG_PATTERN_WORD3:  pattern[3*WORD_BYTES +: WORD_BYTES] <= cfg_data;
        default: ;
      endcase
    end
  end

  // effective pattern length, clamped to the window depth
  assign len_c = (pattern_length > PAT_LEN_W'(MAX_PATTERN_BYTES)) ?
                 PAT_LEN_W'(MAX_PATTERN_BYTES) : pattern_length;

  // saturating line length
  always_comb begin
    if (count == LEN_MAX) begin
      count_next = count;
      ovf_next   = 1'b1;
    end else begin
      count_next = count + 1'b1;
      ovf_next   = ovf;
    end
  end

  // window shift and pattern compare, newest byte at index 0
  always_comb begin
    logic [PAT_LEN_W-1:0] pidx;
    pidx   = '0;
    all_eq = 1'b1;
    window_next[0] = text.data_byte;
    for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
      window_next[i] = window[i-1];
    end
    for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
      pidx = len_c - PAT_LEN_W'(i) - PAT_LEN_W'(1);
      if ((PAT_LEN_W'(i) < len_c) &&
          (window_next[i] != pattern[pidx[PAT_IDX_W-1:0]])) begin
        all_eq = 1'b0;
      end
    end
  end

  assign match = (len_c == '0) ||
                 ((count_next >= LENGTH_BITS'(len_c)) && all_eq);
  assign found_next = found || match;

  // line state update
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
      found <= 1'b0;
    end else if (accept) begin
      if (is_term) begin
        count <= '0;
        ovf   <= 1'b0;
        found <= 1'b0;
      end else begin
        count <= count_next;
        ovf   <= ovf_next;
        found <= found_next;
      end
    end
  end

  // window payload, no reset needed: guarded by the line length
  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  // line record at each terminator
  always_comb begin
    push.valid               = accept && is_term;
    push.rec.keep            = found_next;
    push.rec.line_len        = LINE_LEN_W'(count_next);
    push.rec.length_overflow = ovf_next;
  end

endmodule

### sv/lsf_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_queue
// Short FIFO of finished line records between front and back.
// ---------------------------------------------------------------------------
module lsf_queue
  import lsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rec_xfer_t push,
  output logic      full,
  output rec_xfer_t head,
  input  logic      pop
);

  line_rec_t              slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;
  logic                   do_push;
  logic                   do_pop;

  assign full     = (fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign head.valid = (fill != '0);
  assign head.rec   = slots[rd_ptr];
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && head.valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // record storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.rec;
    end
  end

endmodule

### sv/lsf_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_back
// Numbers kept lines and holds the result in the output register.
// ---------------------------------------------------------------------------
module lsf_back
  import lsf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rec_xfer_t head,
  output logic      pop,
  lsf_line_if.source lines
);

  logic [LINE_NUMBER_W-1:0] kept_count;
  logic [LINE_NUMBER_W-1:0] kept_count_next;
  logic                     out_valid;
  logic                     out_keep;
  logic [LINE_LEN_W-1:0]    out_length;
  logic                     out_ovf;
  logic [LINE_NUMBER_W-1:0] out_number;
  logic                     load;

  assign load            = head.valid && (!out_valid || lines.ready);
  assign pop             = load;
  assign kept_count_next = kept_count + 1'b1;

  // running count over kept lines and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (load && head.rec.keep) kept_count <= kept_count_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (lines.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_keep   <= head.rec.keep;
      out_length <= head.rec.line_len;
      out_ovf    <= head.rec.length_overflow;
      out_number <= head.rec.keep ? kept_count_next : '0;
    end
  end

  assign lines.valid           = out_valid;
  assign lines.keep            = out_keep;
  assign lines.line_len        = out_length;
  assign lines.length_overflow = out_ovf;
  assign lines.line_number     = out_number;

endmodule

### sv/line_substring_filter_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_substring_filter_core
// Streaming line filter: splits text at a terminator byte and reports for
// each line whether it holds a fixed pattern, its length and its number.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  text      sink       data_byte, one byte per transfer
//  lines     source     keep, line_len, length_overflow, line_number
//  cfg_*     sink       register writes, no handshake
//
//  One byte per cycle unless the queue is full; the 32-byte window compare
//  in the front sets the pace. A terminator's record passes the queue and
//  the output register on its way to lines. Reset is synchronous and clears
//  the line state, counters and queue. Up to four line records wait between
//  front and back; text stalls only when that queue is full.
// ---------------------------------------------------------------------------
module line_substring_filter_core
  import lsf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  lsf_byte_if.sink               text,
  lsf_line_if.source             lines
);

  rec_xfer_t push;
  rec_xfer_t head;
  logic      queue_full;
  logic      pop;

  // byte intake and matching
  lsf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .text       (text),
    .queue_full (queue_full),
    .push       (push)
  );

  // line record queue
  lsf_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  // numbering and output register
  lsf_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .lines (lines)
  );

endmodule

### sv/lsf_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lsf_checker
// Port-level checks on the line result channel of the filter.
// ---------------------------------------------------------------------------
`include "line_substring_filter_core_macros.svh"

module lsf_checker
  import lsf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     valid,
  input  logic                     ready,
  input  logic                     keep,
  input  logic [LINE_LEN_W-1:0]    line_len,
  input  logic                     length_overflow,
  input  logic [LINE_NUMBER_W-1:0] line_number
);

  // a stalled result holds its payload
  `LSF_ASSERT_NXT(a_stall_hold, clk, rst, valid && !ready, valid && $stable(line_len) && $stable(line_number) && $stable(keep))

  // dropped lines carry no number
  `LSF_ASSERT_IMP(a_drop_number, clk, rst, valid && !keep, line_number == '0)

  // every line holds at least its terminator
  `LSF_ASSERT_IMP(a_length_nonzero, clk, rst, valid, line_len != '0)

  // a saturated line reports the maximum length
  `LSF_ASSERT_IMP(a_overflow_max, clk, rst, valid && length_overflow, line_len == LINE_LEN_W'(LEN_MAX))

endmodule

bind line_substring_filter_core lsf_checker u_lsf_checker (
  .clk             (clk),
  .rst             (rst),
  .valid           (lines.valid),
  .ready           (lines.ready),
  .keep            (lines.keep),
  .line_len        (lines.line_len),
  .length_overflow (lines.length_overflow),
  .line_number     (lines.line_number)
);

### tb/line_substring_filter_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// line_substring_filter_core_tb
// Self-checking bench for the streaming line filter. Text bytes go in through
// the byte channel and line results are checked field by field against a
// scoreboard that tracks the search window, line length and kept-line count.
// A short directed pass covers the corner cases. Random lines then run under
// several register settings and handshake idling patterns.
// ---------------------------------------------------------------------------
module line_substring_filter_core_tb;
  import lsf_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 6;
  localparam int          SEGMENT_BYTES  = 90;
  localparam int unsigned LINE_LEN_MAX   = (1 << LENGTH_BITS) - 1;

  typedef struct packed {
    logic                     keep;
    logic [LINE_LEN_W-1:0]    line_len;
    logic                     length_overflow;
    logic [LINE_NUMBER_W-1:0] line_number;
  } line_result_t;

  // tracks the filter state and holds the line results still owed
  class line_filter_scoreboard;
    logic [7:0]               terminator;
    logic [PAT_LEN_W-1:0]     pattern_len;
    logic [CFG_DATA_W-1:0]    pattern_word [PATTERN_WORDS];
    logic [7:0]               window [MAX_PATTERN_BYTES];
    bit                       found;
    int unsigned              line_bytes;
    bit                       line_saturated;
    logic [LINE_NUMBER_W-1:0] kept_count;
    line_result_t             pending_lines [$];
    int                       errors;
    int                       bytes_seen;
    int                       lines_checked;
    int                       kept_checked;
    int                       saturated_checked;

    function new();
      terminator  = TERMINATOR_RESET;
      pattern_len = '0;
      foreach (pattern_word[i]) pattern_word[i] = '0;
      foreach (window[i]) window[i] = '0;
      found             = 1'b0;
      line_bytes        = 0;
      line_saturated    = 1'b0;
      kept_count        = '0;
      errors            = 0;
      bytes_seen        = 0;
      lines_checked     = 0;
      kept_checked      = 0;
      saturated_checked = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_TERMINATOR:     terminator = value[7:0];
        REG_PATTERN_LENGTH: pattern_len = value[PAT_LEN_W-1:0];
        REG_PATTERN_WORD0:  pattern_word[0] = value;
        REG_PATTERN_WORD1:  pattern_word[1] = value;
        REG_PATTERN_WORD2:  pattern_word[2] = value;
        REG_PATTERN_WORD3:  pattern_word[3] = value;
        default: ;
      endcase
    endfunction

    function logic [7:0] pattern_byte(int k);
      return pattern_word[k / WORD_BYTES][(k % WORD_BYTES) * 8 +: 8];
    endfunction

    // pattern ends on the newest byte, never reaching into an earlier line
    function bit window_hit();
      int n;
      n = (pattern_len > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(pattern_len);
      if (n == 0) return 1'b1;
      if (line_bytes < n) return 1'b0;
      for (int i = 0; i < n; i++)
        if (window[i] != pattern_byte(n - 1 - i)) return 1'b0;
      return 1'b1;
    endfunction

    // accepted text byte: advance the line state, owe a result at a terminator
    function void note_byte(logic [7:0] b);
      line_result_t res;
      bytes_seen++;
      for (int i = MAX_PATTERN_BYTES - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      if (line_bytes >= LINE_LEN_MAX) line_saturated = 1'b1;
      else line_bytes++;
      if (window_hit()) found = 1'b1;
      if (b != terminator) return;
      if (found) kept_count++;
      res.keep            = found;
      res.line_len        = LINE_LEN_W'(line_bytes);
      res.length_overflow = line_saturated;
      res.line_number     = found ? kept_count : '0;
      pending_lines.insert(pending_lines.size(), res);
      found          = 1'b0;
      line_bytes     = 0;
      line_saturated = 1'b0;
    endfunction

    function void mismatch(string field, longint unsigned want, longint unsigned got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      errors++;
    endfunction

    // accepted line result against the oldest one owed
    function void check_line(line_result_t got);
      line_result_t want;
      if (pending_lines.size() == 0) begin
        $display("%0t: line result with none owed, expected nothing,", $time);
        $display("  actual keep=%0b length=%0d overflow=%0b number=%0d",
                 got.keep, got.line_len, got.length_overflow, got.line_number);
        errors++;
        return;
      end
      want = pending_lines.pop_front();
      lines_checked++;
      if (want.keep) kept_checked++;
      if (want.length_overflow) saturated_checked++;
      if (got.keep != want.keep) mismatch("keep", want.keep, got.keep);
      if (got.line_len != want.line_len)
        mismatch("line_len", want.line_len, got.line_len);
      if (got.length_overflow != want.length_overflow)
        mismatch("length_overflow", want.length_overflow, got.length_overflow);
      if (got.line_number != want.line_number)
        mismatch("line_number", want.line_number, got.line_number);
    endfunction

    function void close();
      if (pending_lines.size() != 0) begin
        $display("%0t: %0d line results never arrived, expected keep=%0b length=%0d, actual none",
                 $time, pending_lines.size(), pending_lines[0].keep,
                 pending_lines[0].line_len);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  lsf_byte_if text ();
  lsf_line_if lines ();

  line_filter_scoreboard sb = new();

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int idle_cycles    = 0;
  int n_settings     = 0;

  // current stimulus setting
  logic [7:0] cur_term;
  logic [7:0] cur_pat [MAX_PATTERN_BYTES];
  logic [7:0] cur_alpha [4];
  int         cur_len;

  line_substring_filter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .text      (text),
    .lines     (lines)
  );

  always #2 clk = ~clk;

  // line results: check each transfer, stall at random
  always @(posedge clk) begin
    if (rst) begin
      lines.ready <= 1'b0;
    end else begin
      if (lines.valid && lines.ready)
        sb.check_line(line_result_t'{lines.keep, lines.line_len,
                                     lines.length_overflow, lines.line_number});
      lines.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no transfer and no register write
  always @(posedge clk) begin
    if (rst || (text.valid && text.ready) || (lines.valid && lines.ready) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one text byte, with random gaps ahead of it; valid stays high afterwards
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      text.valid <= 1'b0;
      @(posedge clk);
    end
    text.valid     <= 1'b1;
    text.data_byte <= b;
    do @(posedge clk); while (!(text.valid && text.ready));
    sb.note_byte(b);
  endtask

  // stop the text, wait for every owed result and the pipeline to empty
  task automatic settle();
    text.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // terminator and pattern for one random segment, extremes on fixed slots
  task automatic choose_setting(input int idx);
    logic [PAT_LEN_W-1:0]  plen;
    logic [CFG_DATA_W-1:0] word;
    case (idx)
      0:       cur_term = TERMINATOR_RESET;
      1:       cur_term = 8'h00;
      2:       cur_term = 8'hFF;
      default: cur_term = 8'($urandom_range(255));
    endcase
    case (idx % 5)
      0:       plen = PAT_LEN_W'(MAX_PATTERN_BYTES);
      1:       plen = (idx == 1) ? 6'd63 : PAT_LEN_W'($urandom_range(33, 62));
      2:       plen = '0;
      3:       plen = 6'd1;
      default: plen = PAT_LEN_W'($urandom_range(2, 6));
    endcase
    cur_len = (plen > MAX_PATTERN_BYTES) ? MAX_PATTERN_BYTES : int'(plen);
    foreach (cur_alpha[a])
      do cur_alpha[a] = 8'($urandom_range(255)); while (cur_alpha[a] == cur_term);
    foreach (cur_pat[k])
      cur_pat[k] = (k < cur_len) ? cur_alpha[$urandom_range(3)] : 8'($urandom_range(255));
    // unused upper data bits carry noise
    word = {$urandom(), $urandom()};
    word[7:0] = cur_term;
    write_reg(REG_TERMINATOR, word);
    word = {$urandom(), $urandom()};
    word[PAT_LEN_W-1:0] = plen;
    write_reg(REG_PATTERN_LENGTH, word);
    for (int w = 0; w < PATTERN_WORDS; w++) begin
      for (int k = 0; k < WORD_BYTES; k++) word[k * 8 +: 8] = cur_pat[w * WORD_BYTES + k];
      write_reg(CFG_INDEX_W'(REG_PATTERN_WORD0 + w), word);
    end
    n_settings++;
  endtask

  // mostly lines from a small alphabet with the pattern planted; some noise
  task automatic send_random_line();
    int len;
    int at;
    int n;
    if ($urandom_range(9) < 7) begin
      len = int'($urandom_range(0, 12));
      at  = (cur_len > 0 && $urandom_range(1)) ? int'($urandom_range(0, len)) : -1;
      for (int i = 0; i <= len; i++) begin
        if (i == at) begin
          // a prefix only now and then, for near misses
          n = ($urandom_range(3) != 0) ? cur_len : int'($urandom_range(1, cur_len));
          for (int k = 0; k < n; k++) send_byte(cur_pat[k]);
        end
        if (i < len) send_byte(cur_alpha[$urandom_range(3)]);
      end
      send_byte(cur_term);
    end else begin
      len = int'($urandom_range(1, 16));
      repeat (len) send_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin
    int seg_start;
    text.valid     = 1'b0;
    text.data_byte = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty pattern after reset keeps every line, the empty line too
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(TERMINATOR_RESET);
    send_byte(TERMINATOR_RESET);
    settle();

    // two-byte pattern "ab", terminator at the top of the byte range
    write_reg(REG_TERMINATOR, 64'hFF);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    write_reg(REG_PATTERN_WORD0, 64'h6261);
    n_settings++;
    send_byte("x");
    send_byte("a");
    send_byte("b");
    send_byte(8'hFF);
    send_byte("a");
    send_byte(8'hFF);
    settle();

    // pattern across a line break never matches
    write_reg(REG_PATTERN_WORD0, 64'h62FF);
    send_byte("b");
    send_byte(8'hFF);
    settle();

    // match ending on the terminator itself
    write_reg(REG_PATTERN_WORD0, 64'hFF61);
    send_byte("a");
    send_byte(8'hFF);
    settle();

    // registers changed mid-line: the match found stays, new terminator ends it
    write_reg(REG_PATTERN_WORD0, 64'h6261);
    send_byte("a");
    send_byte("b");
    settle();
    write_reg(REG_PATTERN_WORD0, 64'h7A7A);
    write_reg(REG_TERMINATOR, 64'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    settle();

    // random lines under three idling patterns
    for (int phase = 0; phase < 3; phase++) begin
      send_gap_pct   = (phase == 0) ? 38 : (phase == 1) ? 61 : 0;
      recv_stall_pct = (phase == 0) ? 61 : (phase == 1) ? 38 : 0;
      for (int s = 0; s < 3; s++) begin
        settle();
        choose_setting(phase * 3 + s);
        seg_start = sb.bytes_seen;
        while (sb.bytes_seen - seg_start < SEGMENT_BYTES) send_random_line();
      end
    end
    settle();

    sb.close();
    $display("run covered %0d text bytes and %0d line results under %0d register settings",
             sb.bytes_seen, sb.lines_checked, n_settings);
    $display("of those lines %0d were kept and %0d hit the length limit",
             sb.kept_checked, sb.saturated_checked);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/lsf_pkg.sv
sv/lsf_byte_if.sv
sv/lsf_line_if.sv
sv/lsf_front.sv
sv/lsf_queue.sv
sv/lsf_back.sv
sv/line_substring_filter_core.sv
sv/lsf_checker.sv
tb/line_substring_filter_core_tb.sv
